/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/asp_pkg.sv */
// Package with the types, constants and register codes of the stripe shader.
package asp_pkg;

   localparam int QuotW = 16;
   localparam int ThickW = 14;
   localparam int SumW = ThickW + 1;
   localparam int DvsW = SumW + QuotW;
   localparam int CellCount = QuotW;

   localparam logic [2:0] RegStepX = 3'd0;
   localparam logic [2:0] RegStepY = 3'd1;
   localparam logic [2:0] RegOffset = 3'd2;
   localparam logic [2:0] RegEvenThick = 3'd3;
   localparam logic [2:0] RegOddThick = 3'd4;
   localparam logic [2:0] RegEvenColor = 3'd5;
   localparam logic [2:0] RegOddColor = 3'd6;

   typedef struct packed {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic span_last_in;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic span_last_out;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic [QuotW-1:0] rem;
      logic [15:0] frac;
      logic last;
   } cell_data_type;

endpackage

/* rtl/antialiased_stripe_pixel_shader_top.sv */
// Top level of the stripe shader: registers, projection stage, remainder cells, color stage.
// Each item passes through one product stage, sixteen remainder cells and one color
// stage, in that order.
// Throughput: one item per cycle; the whole pipeline advances when the result
// register is empty or its item is taken.
// Reset clears all valid bits and loads the registers with their reset values.
module antialiased_stripe_pixel_shader_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  asp_pkg::req_item_type req_item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output asp_pkg::rsp_item_type rsp_item,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] step_x_ff;
   logic [31:0] step_y_ff;
   logic [31:0] offset_ff;
   logic [asp_pkg::ThickW-1:0] even_thick_ff;
   logic [asp_pkg::ThickW-1:0] odd_thick_ff;
   logic [31:0] even_color_ff;
   logic [31:0] odd_color_ff;

   logic en;
   logic s1_valid_ff;
   logic s1_last_ff;
   logic [31:0] prod_x_ff;
   logic [31:0] prod_y_ff;
   logic [31:0] raw;
   logic [15:0] quot;
   logic [asp_pkg::ThickW-1:0] t0;
   logic [asp_pkg::ThickW-1:0] t1;
   logic [asp_pkg::SumW-1:0] tsum;
   asp_pkg::cell_data_type head;
   asp_pkg::cell_data_type chain [asp_pkg::CellCount+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff <= 32'd0;
         step_y_ff <= 32'd65536;
         offset_ff <= 32'd0;
         even_thick_ff <= asp_pkg::ThickW'(1);
         odd_thick_ff <= asp_pkg::ThickW'(1);
         even_color_ff <= 32'd0;
         odd_color_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            asp_pkg::RegStepX: step_x_ff <= csr_wdata;
            asp_pkg::RegStepY: step_y_ff <= csr_wdata;
            asp_pkg::RegOffset: offset_ff <= csr_wdata;
            asp_pkg::RegEvenThick: even_thick_ff <= csr_wdata[asp_pkg::ThickW-1:0];
            asp_pkg::RegOddThick: odd_thick_ff <= csr_wdata[asp_pkg::ThickW-1:0];
            asp_pkg::RegEvenColor: even_color_ff <= csr_wdata;
            asp_pkg::RegOddColor: odd_color_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_last_ff <= req_item.span_last_in;
         prod_x_ff <= step_x_ff * {{16{req_item.pixel_x[15]}}, req_item.pixel_x};
         prod_y_ff <= step_y_ff * {{16{req_item.pixel_y[15]}}, req_item.pixel_y};
      end
   end

   always_comb begin
      t0 = (even_thick_ff == '0) ? asp_pkg::ThickW'(1) : even_thick_ff;
      t1 = (odd_thick_ff == '0) ? asp_pkg::ThickW'(1) : odd_thick_ff;
      tsum = asp_pkg::SumW'(t0) + asp_pkg::SumW'(t1);
      raw = prod_x_ff + prod_y_ff + offset_ff;
      quot = raw[31:16];
      head.valid = s1_valid_ff;
      head.neg = quot[15];
      head.rem = quot[15] ? (16'd0 - quot) : quot;
      head.frac = raw[15:0];
      head.last = s1_last_ff;
   end

   assign chain[0] = head;

   for (genvar k = 0; k < asp_pkg::CellCount; k++) begin : g_cell
      logic [asp_pkg::DvsW-1:0] dvs;
      assign dvs = asp_pkg::DvsW'(tsum) << (asp_pkg::CellCount - 1 - k);
      asp_cell u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .dvs(dvs),
         .din(chain[k]),
         .dout(chain[k+1])
      );
   end

   asp_shade u_shade (
      .clock(clock),
      .reset(reset),
      .en(en),
      .din(chain[asp_pkg::CellCount]),
      .thick_even(t0),
      .thick_sum(tsum),
      .even_color(even_color_ff),
      .odd_color(odd_color_ff),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

endmodule

/* rtl/asp_cell.sv */
// One restoring remainder cell: subtracts its shifted divisor when it fits.
module asp_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic [asp_pkg::DvsW-1:0] dvs,
   input  asp_pkg::cell_data_type din,
   output asp_pkg::cell_data_type dout
);

   asp_pkg::cell_data_type data_ff;
   asp_pkg::cell_data_type data_in;
   logic [asp_pkg::DvsW-1:0] wide_rem;
   logic [asp_pkg::DvsW-1:0] diff;

   always_comb begin
      wide_rem = {{(asp_pkg::DvsW-asp_pkg::QuotW){1'b0}}, din.rem};
      diff = wide_rem - dvs;
      data_in = din;
      if (wide_rem >= dvs) begin
         data_in.rem = diff[asp_pkg::QuotW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (en) begin
         data_ff.valid <= data_in.valid;
      end
      if (en) begin
         data_ff.neg <= data_in.neg;
         data_ff.rem <= data_in.rem;
         data_ff.frac <= data_in.frac;
         data_ff.last <= data_in.last;
      end
   end

   assign dout = data_ff;

endmodule

/* rtl/asp_shade.sv */
// Final stage: folds the remainder positive, picks or blends the colour, holds the item.
module asp_shade (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  asp_pkg::cell_data_type din,
   input  logic [asp_pkg::ThickW-1:0] thick_even,
   input  logic [asp_pkg::SumW-1:0] thick_sum,
   input  logic [31:0] even_color,
   input  logic [31:0] odd_color,
   output logic rsp_valid,
   output asp_pkg::rsp_item_type rsp_item
);

   logic valid_ff;
   asp_pkg::rsp_item_type item_ff;
   asp_pkg::rsp_item_type item_in;
   logic [asp_pkg::SumW-1:0] kq;
   logic [asp_pkg::SumW-1:0] rem_ext;
   logic [8:0] w;
   logic [31:0] ca;
   logic [31:0] cb;
   logic [31:0] hi;
   logic [31:0] lo;
   logic [31:0] blended;
   logic use_blend;

   always_comb begin
      rem_ext = asp_pkg::SumW'(din.rem);
      if (din.neg && (din.rem != '0)) begin
         kq = thick_sum - rem_ext;
      end else begin
         kq = rem_ext;
      end
      w = 9'd1 + {1'b0, din.frac[15:8]};
      use_blend = 1'b0;
      ca = even_color;
      cb = odd_color;
      if (kq >= asp_pkg::SumW'(thick_even)) begin
         ca = odd_color;
         cb = even_color;
         use_blend = (kq == asp_pkg::SumW'(thick_even));
      end else begin
         use_blend = (kq == '0);
      end
      hi = ((((ca >> 8) & 32'h00ff00ff) - ((cb >> 8) & 32'h00ff00ff)) * {23'd0, w}
            + (cb & 32'hff00ff00)) & 32'hff00ff00;
      lo = (((((ca & 32'h00ff00ff) - (cb & 32'h00ff00ff)) * {23'd0, w}) >> 8)
            + (cb & 32'h00ff00ff)) & 32'h00ff00ff;
      blended = hi + lo;
      item_in.pixel_color = use_blend ? blended : ca;
      item_in.span_last_out = din.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= din.valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item = item_ff;

endmodule

/* rtl/asp_checker.sv */
// Port checker for the stripe shader top level, with its bind statement.
`include "assert_macros.svh"

module asp_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input asp_pkg::rsp_item_type rsp_item
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

endmodule

bind antialiased_stripe_pixel_shader_top asp_checker u_asp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item(rsp_item)
);
